// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the top-level design file. They are empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHR_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define CHR_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define CHR_ASSERT(label, clk, rst, prop)
`define CHR_ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ===== design/chr_pkg.sv =====
// ----------------------------------------------------------------------------
// chr_pkg
// Types, constants and hash helpers for the consistent hash ring.
// ----------------------------------------------------------------------------
package chr_pkg;

  localparam logic [31:0] HASH_PRIME = 32'd16777619;
  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [7:0]  SEP_CHAR   = 8'h23;
  localparam logic [7:0]  DIGIT_ZERO = 8'h30;

  localparam int RING_DEPTH_DEF = 1024;
  localparam int MaxVirtualPoints = 64;
  localparam logic [6:0] VPOINTS_RESET = 7'd4;

  localparam logic [1:0] ACT_LOOKUP = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [5:0]  server;
    logic [31:0] name_state;
  } op_t;

  typedef struct packed {
    logic [31:0] point;
    logic [5:0]  owner;
  } entry_t;

  typedef struct packed {
    logic [5:0]  owner_number;
    logic [31:0] key_hash;
    logic [1:0]  status;
    logic [10:0] points_in_ring;
  } result_t;

  typedef struct packed {
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  function automatic logic [31:0] hash_byte(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * HASH_PRIME;
  endfunction

  // First half of the finalizer.
  function automatic logic [31:0] mix_a(input logic [31:0] h);
    logic [31:0] t;
    t = h + (h << 13);
    t = t ^ (t >> 7);
    return t;
  endfunction

  // Second half of the finalizer.
  function automatic logic [31:0] mix_b(input logic [31:0] h);
    logic [31:0] t;
    t = h + (h << 3);
    t = t ^ (t >> 17);
    t = t + (t << 5);
    return t;
  endfunction

  function automatic digits_t split_digits(input logic [6:0] j);
    digits_t d;
    logic [6:0] r;
    d.hund = (j >= 7'd100) ? 4'd1 : 4'd0;
    r = (j >= 7'd100) ? (j - 7'd100) : j;
    d.tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (r >= 7'(10 * k)) begin
        d.tens = 4'(k);
      end
    end
    d.ones = 4'(r - 7'({3'd0, d.tens} * 7'd10));
    return d;
  endfunction

endpackage

// ===== design/chr_front.sv =====
// ----------------------------------------------------------------------------
// chr_front
// Folds incoming bytes into the running hash and queues finished operations.
// ----------------------------------------------------------------------------
module chr_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       action,
  input  logic [7:0]       data_byte,
  input  logic             last_byte,
  input  logic [5:0]       server_number,
  output logic             q_push,
  output chr_pkg::op_t     q_data,
  input  logic             q_full
);

  logic [31:0] running_hash;
  logic [31:0] hash_next;
  logic        accept;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign hash_next = chr_pkg::hash_byte(running_hash, data_byte);

  assign q_push            = accept && last_byte;
  assign q_data.action     = action;
  assign q_data.server     = server_number;
  assign q_data.name_state = hash_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= chr_pkg::HASH_BASIS;
    end else if (accept) begin
      running_hash <= last_byte ? chr_pkg::HASH_BASIS : hash_next;
    end
  end

endmodule

// ===== design/chr_queue.sv =====
// ----------------------------------------------------------------------------
// chr_queue
// Two-entry queue of pending operations between front and back.
// ----------------------------------------------------------------------------
module chr_queue (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  chr_pkg::op_t push_data,
  output logic         full,
  input  logic         pop,
  output chr_pkg::op_t pop_data,
  output logic         valid
);

  chr_pkg::op_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full     = (fill == 2'd2);
  assign valid    = (fill != 2'd0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop && valid) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + 2'((push && !full) ? 1 : 0) - 2'((pop && valid) ? 1 : 0);
    end
  end

endmodule

// ===== design/chr_ring.sv =====
// ----------------------------------------------------------------------------
// chr_ring
// Ring engine: finishes hashes, searches the sorted ring, inserts and deletes.
// ----------------------------------------------------------------------------
module chr_ring #(
  parameter int RING_DEPTH = chr_pkg::RING_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  chr_pkg::op_t     q_data,
  output logic             q_pop,
  input  logic [6:0]       vpoints_cfg,
  output logic             res_valid,
  input  logic             res_ready,
  output chr_pkg::result_t res,
  output logic [$clog2(RING_DEPTH+1)-1:0] ring_count
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CW = $clog2(RING_DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_KA, S_KB, S_PH, S_P100, S_P10, S_P1, S_PA, S_PB,
    S_SRCH, S_SCMP, S_LOOK, S_CHK, S_SHR, S_SHW, S_NEXT, S_OUT
  } state_t;

  state_t state;

  chr_pkg::entry_t mem [RING_DEPTH];
  chr_pkg::entry_t rd_q;
  chr_pkg::entry_t wr_data;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   wr_addr;
  logic            wr_en;

  logic [1:0]    act;
  logic [5:0]    server;
  logic [31:0]   name;
  logic [31:0]   h;
  logic [31:0]   key_hash;
  logic [31:0]   target;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [CW-1:0] midq;
  logic [CW-1:0] i;
  logic [CW-1:0] count;
  logic [6:0]    j;
  logic [6:0]    n;
  logic [1:0]    status;
  logic [5:0]    owner;

  logic [CW-1:0]    mid;
  logic [CW-1:0]    lo_sel;
  logic [6:0]       vsat;
  logic             present;
  chr_pkg::digits_t dg;

  assign mid  = lo + ((hi - lo) >> 1);
  assign lo_sel = (lo >= count) ? '0 : lo;
  assign vsat = (vpoints_cfg > 7'(chr_pkg::MaxVirtualPoints)) ?
                7'(chr_pkg::MaxVirtualPoints) : vpoints_cfg;
  assign present = (lo < count) && (rd_q.point == target);
  assign dg = chr_pkg::split_digits(j);
  assign q_pop = (state == S_IDLE) && q_valid;
  assign ring_count = count;

  always_comb begin
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = i[AW-1:0];
    wr_data = rd_q;
    unique case (state)
      S_SRCH: begin
        if (lo < hi) begin
          rd_addr = mid[AW-1:0];
        end else if (act == chr_pkg::ACT_LOOKUP) begin
          rd_addr = lo_sel[AW-1:0];
        end else begin
          rd_addr = lo[AW-1:0];
        end
      end
      S_SHR: begin
        if (act == chr_pkg::ACT_ADD) begin
          rd_addr = AW'(i - CW'(1));
          if (i <= lo) begin
            wr_en        = 1'b1;
            wr_addr      = lo[AW-1:0];
            wr_data.point = target;
            wr_data.owner = server;
          end
        end else begin
          rd_addr = AW'(i + CW'(1));
        end
      end
      S_SHW: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      // In S_OUT the output register is reloaded below instead.
      if (res_valid && res_ready && state != S_OUT) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            act    <= q_data.action;
            server <= q_data.server;
            name   <= q_data.name_state;
            h      <= q_data.name_state;
            state  <= S_KA;
          end
        end
        S_KA: begin
          h     <= chr_pkg::mix_a(h);
          state <= S_KB;
        end
        S_KB: begin
          key_hash <= chr_pkg::mix_b(h);
          target   <= chr_pkg::mix_b(h);
          owner    <= '0;
          status   <= chr_pkg::ST_OK;
          j        <= '0;
          n        <= vsat;
          lo       <= '0;
          hi       <= count;
          case (act) inside
            chr_pkg::ACT_LOOKUP: begin
              if (count == '0) begin
                status <= chr_pkg::ST_EMPTY;
                state  <= S_OUT;
              end else begin
                state <= S_SRCH;
              end
            end
            chr_pkg::ACT_ADD, chr_pkg::ACT_DELETE: begin
              state <= (vsat == 7'd0) ? S_OUT : S_PH;
            end
            default: begin
              state <= S_OUT;
            end
          endcase
        end
        S_PH: begin
          h     <= chr_pkg::hash_byte(name, chr_pkg::SEP_CHAR);
          state <= S_P100;
        end
        S_P100: begin
          if (dg.hund != 4'd0) begin
            h <= chr_pkg::hash_byte(h, chr_pkg::DIGIT_ZERO + {4'd0, dg.hund});
          end
          state <= S_P10;
        end
        S_P10: begin
          if (dg.hund != 4'd0 || dg.tens != 4'd0) begin
            h <= chr_pkg::hash_byte(h, chr_pkg::DIGIT_ZERO + {4'd0, dg.tens});
          end
          state <= S_P1;
        end
        S_P1: begin
          h     <= chr_pkg::hash_byte(h, chr_pkg::DIGIT_ZERO + {4'd0, dg.ones});
          state <= S_PA;
        end
        S_PA: begin
          h     <= chr_pkg::mix_a(h);
          state <= S_PB;
        end
        S_PB: begin
          target <= chr_pkg::mix_b(h);
          lo     <= '0;
          hi     <= count;
          state  <= S_SRCH;
        end
        S_SRCH: begin
          if (lo < hi) begin
            midq  <= mid;
            state <= S_SCMP;
          end else if (act == chr_pkg::ACT_LOOKUP) begin
            state <= S_LOOK;
          end else begin
            state <= S_CHK;
          end
        end
        S_SCMP: begin
          if (rd_q.point < target) begin
            lo <= midq + CW'(1);
          end else begin
            hi <= midq;
          end
          state <= S_SRCH;
        end
        S_LOOK: begin
          owner <= rd_q.owner;
          state <= S_OUT;
        end
        S_CHK: begin
          if (act == chr_pkg::ACT_ADD) begin
            if (present) begin
              state <= S_NEXT;
            end else if (count >= CW'(RING_DEPTH)) begin
              status <= chr_pkg::ST_FULL;
              state  <= S_NEXT;
            end else begin
              i     <= count;
              state <= S_SHR;
            end
          end else if (present) begin
            i     <= lo;
            state <= S_SHR;
          end else begin
            state <= S_NEXT;
          end
        end
        S_SHR: begin
          // Entries move one slot per pass: read here, write in S_SHW.
          if (act == chr_pkg::ACT_ADD) begin
            if (i > lo) begin
              state <= S_SHW;
            end else begin
              count <= count + CW'(1);
              state <= S_NEXT;
            end
          end else if ((i + CW'(1)) < count) begin
            state <= S_SHW;
          end else begin
            count <= count - CW'(1);
            state <= S_NEXT;
          end
        end
        S_SHW: begin
          i     <= (act == chr_pkg::ACT_ADD) ? (i - CW'(1)) : (i + CW'(1));
          state <= S_SHR;
        end
        S_NEXT: begin
          if ((j + 7'd1) < n) begin
            j     <= j + 7'd1;
            state <= S_PH;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid || res_ready) begin
            res_valid          <= 1'b1;
            res.owner_number   <= owner;
            res.key_hash       <= key_hash;
            res.status         <= status;
            res.points_in_ring <= 11'(count);
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/consistent_hash_ring_core.sv =====
// ----------------------------------------------------------------------------
// consistent_hash_ring_core
// Sorted ring of hashed points with byte-streamed lookup, add and delete.
// ----------------------------------------------------------------------------
// Bytes of a key or server name arrive on the s_ channel, one transaction per
// byte, with tlast on the final byte. tuser carries the action (lookup, add,
// delete). Non-final bytes are hashed at one per cycle while s_tready is high
// and give no result. The final byte queues an operation for the ring engine;
// one result transaction per final byte leaves on the m_ channel.
// A lookup finishes the key hash and binary-searches the ring. An add or
// delete, per virtual point, hashes the point, binary-searches the ring and
// shifts the ring entries that move, one slot at a time.
// The ring memory is not cleared: reset zeroes the point count, sets the
// running hash to its basis, and the block is ready in the cycle after reset.
// A stalled receiver holds the result in the output register; the engine and
// then the two-entry operation queue fill, and s_tready drops.
// cfg_we writes the virtual points per server (reset value 4).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module consistent_hash_ring_core #(
  parameter int RING_DEPTH = chr_pkg::RING_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] data_byte, [13:8] server_number
  input  logic [1:0]  s_tuser,   // [1:0] action
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [5:0] owner_number, [37:6] key_hash,
                                 // [48:38] points_in_ring
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  localparam int CW = $clog2(RING_DEPTH + 1);

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_valid;
  chr_pkg::op_t     q_in;
  chr_pkg::op_t     q_out;
  chr_pkg::result_t res;
  logic [6:0]       vpoints;
  logic [CW-1:0]    ring_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpoints <= chr_pkg::VPOINTS_RESET;
    end else if (cfg_we) begin
      vpoints <= cfg_wdata;
    end
  end

  chr_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .action        (s_tuser),
    .data_byte     (s_tdata[7:0]),
    .last_byte     (s_tlast),
    .server_number (s_tdata[13:8]),
    .q_push        (q_push),
    .q_data        (q_in),
    .q_full        (q_full)
  );

  chr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .valid     (q_valid)
  );

  chr_ring #(
    .RING_DEPTH (RING_DEPTH)
  ) u_ring (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_data      (q_out),
    .q_pop       (q_pop),
    .vpoints_cfg (vpoints),
    .res_valid   (m_tvalid),
    .res_ready   (m_tready),
    .res         (res),
    .ring_count  (ring_count)
  );

  assign m_tdata = {7'd0, res.points_in_ring, res.key_hash, res.owner_number};
  assign m_tuser = res.status;

  `CHR_ASSERT(a_queue_no_overflow, clk, rst, q_push |-> !q_full)
  `CHR_ASSERT_NEXT(a_queue_holds_push, clk, rst, q_push, q_valid)
  `CHR_ASSERT(a_count_in_range, clk, rst, ring_count <= CW'(RING_DEPTH))

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the consistent hash ring core. Byte streams of keys
// and server names are sent with random gaps and stalls, and every result
// transaction is compared with a behavioral model of the sorted ring.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NumRandomOps = 420;

  typedef struct {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic       last_byte;
    logic [5:0] server_number;
    int         hold_cycles;  // Non-zero: pause until the ring is drained.
    int         cfg_value;    // Not read by the driver; items set it to -1.
  } byte_item_t;

  typedef struct {
    logic [5:0]  owner_number;
    logic [31:0] key_hash;
    logic [1:0]  status;
    logic [10:0] points_in_ring;
  } ring_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we = 1'b0;
  logic [6:0]  cfg_wdata = '0;

  consistent_hash_ring_core uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Model state.
  logic [31:0]  mdl_points[$];
  logic [5:0]   mdl_owners[$];
  logic [31:0]  mdl_hash = chr_pkg::HASH_BASIS;
  logic [6:0]   mdl_vpoints = chr_pkg::VPOINTS_RESET;

  byte_item_t   pending_bytes[$];
  ring_result_t expected_results[$];
  int           mismatches = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_off = 0;
  int           pause_left = 0;
  string        server_names[8];

  function automatic logic [31:0] fnv_step(logic [31:0] h, logic [7:0] b);
    return (h ^ {24'd0, b}) * 32'd16777619;
  endfunction

  function automatic logic [31:0] finish_hash(logic [31:0] h);
    h = h + (h << 13);
    h = h ^ (h >> 7);
    h = h + (h << 3);
    h = h ^ (h >> 17);
    h = h + (h << 5);
    return h;
  endfunction

  function automatic logic [31:0] virtual_point(logic [31:0] name_state, int j);
    logic [31:0] h;
    h = fnv_step(name_state, 8'h23);
    if (j >= 10) h = fnv_step(h, 8'(8'h30 + j / 10));
    return finish_hash(fnv_step(h, 8'(8'h30 + j % 10)));
  endfunction

  function automatic int first_at_or_above(logic [31:0] v);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = mdl_points.size();
    while (lo < hi) begin
      mid = (lo + hi) / 2;
      if (mdl_points[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // Advances the ring model by one accepted byte; queues a result on tlast.
  task automatic ring_model_step(byte_item_t it);
    ring_result_t r;
    logic [31:0] name_state;
    logic [31:0] pt;
    int n;
    int p;
    mdl_hash = fnv_step(mdl_hash, it.data_byte);
    if (it.last_byte) begin
      name_state = mdl_hash;
      mdl_hash = chr_pkg::HASH_BASIS;
      r.key_hash = finish_hash(name_state);
      r.owner_number = '0;
      r.status = chr_pkg::ST_OK;
      n = (mdl_vpoints > 7'd64) ? 64 : int'(mdl_vpoints);
      if (it.action == chr_pkg::ACT_LOOKUP) begin
        if (mdl_points.size() == 0) begin
          r.status = chr_pkg::ST_EMPTY;
        end else begin
          p = first_at_or_above(r.key_hash);
          if (p >= mdl_points.size()) p = 0;
          r.owner_number = mdl_owners[p];
        end
      end else if (it.action == chr_pkg::ACT_ADD) begin
        for (int j = 0; j < n; j++) begin
          pt = virtual_point(name_state, j);
          p = first_at_or_above(pt);
          if (p < mdl_points.size() && mdl_points[p] == pt) continue;
          if (mdl_points.size() >= chr_pkg::RING_DEPTH_DEF) begin
            r.status = chr_pkg::ST_FULL;
            continue;
          end
          mdl_points.insert(p, pt);
          mdl_owners.insert(p, it.server_number);
        end
      end else if (it.action == chr_pkg::ACT_DELETE) begin
        for (int j = 0; j < n; j++) begin
          pt = virtual_point(name_state, j);
          p = first_at_or_above(pt);
          if (p < mdl_points.size() && mdl_points[p] == pt) begin
            mdl_points.delete(p);
            mdl_owners.delete(p);
          end
        end
      end
      r.points_in_ring = 11'(mdl_points.size());
      expected_results.push_back(r);
    end
  endtask

  task automatic push_stream(logic [1:0] act, string s, logic [5:0] srv);
    byte_item_t it;
    for (int k = 0; k < s.len(); k++) begin
      it.action = act;
      it.data_byte = s[k];
      it.last_byte = (k == s.len() - 1);
      it.server_number = srv;
      it.hold_cycles = 0;
      it.cfg_value = -1;
      pending_bytes.push_back(it);
    end
  endtask

  task automatic push_random_key(logic [1:0] act, int len);
    byte_item_t it;
    for (int k = 0; k < len; k++) begin
      it.action = act;
      it.data_byte = 8'($urandom);
      it.last_byte = (k == len - 1);
      it.server_number = 6'($urandom);
      it.hold_cycles = 0;
      it.cfg_value = -1;
      pending_bytes.push_back(it);
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || expected_results.size() != 0 || s_tvalid)
      @(posedge clk);
    repeat (4000) @(posedge clk);
  endtask

  task automatic write_vpoints(int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= 7'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    mdl_vpoints = 7'(v);
  endtask

  task automatic random_phase(int ops, int idle_pct, int stall_pct);
    int sel;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < ops; i++) begin
      sel = $urandom_range(0, 9);
      if (sel < 5)
        push_random_key(chr_pkg::ACT_LOOKUP, $urandom_range(1, 4));
      else if (sel < 7)
        push_stream(chr_pkg::ACT_ADD, server_names[$urandom_range(0, 7)],
                    6'($urandom));
      else if (sel < 8)
        push_stream(chr_pkg::ACT_DELETE, server_names[$urandom_range(0, 7)],
                    6'($urandom));
      else if (sel < 9)
        push_random_key(chr_pkg::ACT_ADD, $urandom_range(1, 3));
      else
        push_random_key(2'($urandom), $urandom_range(1, 3));
    end
    wait_drained();
  endtask

  // Driver: one byte transaction per handshake.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) ring_model_step(pending_bytes.pop_front());
      if (pause_left > 0) begin
        pause_left <= pause_left - 1;
        s_tvalid <= 1'b0;
      end else if (pending_bytes.size() != 0 && pending_bytes[0].hold_cycles != 0 &&
                   (expected_results.size() != 0 || s_tvalid)) begin
        s_tvalid <= 1'b0;
      end else if (pending_bytes.size() != 0 &&
                   $urandom_range(0, 99) >= send_idle_pct) begin
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, pending_bytes[0].server_number, pending_bytes[0].data_byte};
        s_tuser <= pending_bytes[0].action;
        s_tlast <= pending_bytes[0].last_byte;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, with a long hold-off when hold_off is set.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Monitor: compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    ring_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result tdata=%h", m_tdata);
      end else begin
        exp_r = expected_results.pop_front();
        if (m_tdata[5:0] !== exp_r.owner_number || m_tdata[37:6] !== exp_r.key_hash ||
            m_tdata[48:38] !== exp_r.points_in_ring || m_tuser !== exp_r.status) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display({"mismatch: exp owner=%0d hash=%h status=%0d points=%0d, ",
                      "got owner=%0d hash=%h status=%0d points=%0d"},
                     exp_r.owner_number, exp_r.key_hash, exp_r.status,
                     exp_r.points_in_ring, m_tdata[5:0], m_tdata[37:6], m_tuser,
                     m_tdata[48:38]);
        end
      end
    end
  end

  initial begin
    #200000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    byte_item_t it;
    server_names = '{"alpha", "b", "cache-07", "node_3", "Z", "srv99", "east", "x1"};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty ring, extremes, every action, byte values 00 and FF.
    push_stream(chr_pkg::ACT_LOOKUP, "k", 6'd0);
    push_stream(chr_pkg::ACT_DELETE, "alpha", 6'd0);
    push_stream(chr_pkg::ACT_ADD, "alpha", 6'd63);
    push_stream(chr_pkg::ACT_ADD, "alpha", 6'd5);
    push_stream(chr_pkg::ACT_ADD, "b", 6'd0);
    push_stream(2'd3, "q", 6'd1);
    it = '{chr_pkg::ACT_LOOKUP, 8'hFF, 1'b0, 6'd63, 0, -1};
    pending_bytes.push_back(it);
    it = '{chr_pkg::ACT_ADD, 8'h00, 1'b0, 6'd0, 0, -1};
    pending_bytes.push_back(it);
    it = '{chr_pkg::ACT_LOOKUP, 8'hAA, 1'b1, 6'd42, 0, -1};
    pending_bytes.push_back(it);
    push_stream(chr_pkg::ACT_DELETE, "b", 6'd0);
    push_stream(chr_pkg::ACT_LOOKUP, "b", 6'd0);
    random_phase(0, 0, 0);

    write_vpoints(0);
    push_stream(chr_pkg::ACT_ADD, "east", 6'd9);
    push_stream(chr_pkg::ACT_DELETE, "alpha", 6'd9);
    random_phase(20, 0, 0);
    write_vpoints(64);
    random_phase(30, 68, 0);
    write_vpoints(127);
    random_phase(NumRandomOps / 4, 0, 68);
    write_vpoints(1);
    random_phase(60, 20, 20);

    // Long receiver hold-off to back up the engine and queue.
    write_vpoints(13);
    hold_off = 600;
    random_phase(40, 0, 0);
    // Sender pause until drained, then more traffic.
    write_vpoints(4);
    for (int i = 0; i < 6; i++) begin
      push_stream(chr_pkg::ACT_ADD, server_names[i], 6'(i));
    end
    push_random_key(chr_pkg::ACT_LOOKUP, 2);
    pending_bytes[pending_bytes.size() - 2].hold_cycles = 1;
    random_phase(NumRandomOps / 4, 0, 0);

    // Fill the ring to its limit with many names at the maximum count.
    write_vpoints(64);
    for (int i = 0; i < 18; i++) begin
      push_random_key(chr_pkg::ACT_ADD, 2);
      push_random_key(chr_pkg::ACT_LOOKUP, 2);
    end
    random_phase(0, 0, 0);
    write_vpoints(2);
    random_phase(60, 68, 68);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/chr_pkg.sv
design/chr_front.sv
design/chr_queue.sv
design/chr_ring.sv
design/consistent_hash_ring_core.sv
tb/sv/tb_top.sv
